### hw/rtl/arpht_pkg.sv
// ----------------------------------------------------------------------------
// ARP hash table package
// Shared types, sizes and helpers for the hashed IPv4-to-MAC table.
// ----------------------------------------------------------------------------
package arpht_pkg;

  // Table geometry. The bucket is the address modulo NUM_BUCKETS, which is
  // kept a power of two so that the bucket is the low address bits.
  localparam int NUM_BUCKETS     = 128;
  localparam int WAYS_PER_BUCKET = 4;

  localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W  = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam int FILL_W = $clog2(WAYS_PER_BUCKET + 1);

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef entry_t [WAYS_PER_BUCKET-1:0] row_t;

  // Write to one way of one bucket, with the new fill count of that bucket.
  typedef struct packed {
    logic              en;
    logic [BKT_W-1:0]  bucket;
    logic [WAY_W-1:0]  way;
    logic [FILL_W-1:0] fill;
    entry_t            entry;
  } wr_req_t;

  typedef struct packed {
    logic             found;
    logic [MAC_W-1:0] mac;
    logic             full;
  } result_t;

  function automatic logic [BKT_W-1:0] bucket_of(logic [IP_W-1:0] ip);
    return BKT_W'(ip % NUM_BUCKETS);
  endfunction

endpackage

### hw/rtl/arpht_store.sv
// ----------------------------------------------------------------------------
// ARP hash table storage
// Bucket rows, fill counts and per-bucket valid bits.
// ----------------------------------------------------------------------------
module arpht_store import arpht_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [BKT_W-1:0]  rd_bucket_i,
  output row_t              rd_row_o,
  output logic [FILL_W-1:0] rd_fill_o,
  input  logic [BKT_W-1:0]  vld_bucket_i,
  output logic              vld_o,
  input  wr_req_t           wr_i,
  input  logic              clear_i
);

  row_t              row_mem  [NUM_BUCKETS];
  logic [FILL_W-1:0] fill_mem [NUM_BUCKETS];
  row_t              rd_row_q;
  logic [FILL_W-1:0] rd_fill_q;
  logic [NUM_BUCKETS-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      row_mem[wr_i.bucket][wr_i.way] <= wr_i.entry;
      fill_mem[wr_i.bucket]          <= wr_i.fill;
    end
    if (rd_en_i) begin
      rd_row_q  <= row_mem[rd_bucket_i];
      rd_fill_q <= fill_mem[rd_bucket_i];
    end
  end

  // A bucket whose valid bit is low counts as empty, so clear only drops the valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.bucket] <= 1'b1;
    end
  end

  assign rd_row_o  = rd_row_q;
  assign rd_fill_o = rd_fill_q;
  assign vld_o     = vld_q[vld_bucket_i];

endmodule

### hw/rtl/arpht_core.sv
// ----------------------------------------------------------------------------
// ARP hash table command logic
// Merges the last write into the bucket row, then inserts or looks up.
// ----------------------------------------------------------------------------
module arpht_core import arpht_pkg::*; (
  input  logic [1:0]        cmd_i,
  input  logic [IP_W-1:0]   ip_i,
  input  logic [MAC_W-1:0]  mac_i,
  input  logic [BKT_W-1:0]  bucket_i,
  input  row_t              rd_row_i,
  input  logic [FILL_W-1:0] rd_fill_i,
  input  logic              bkt_vld_i,
  input  wr_req_t           byp_i,
  output result_t           res_o,
  output wr_req_t           wr_o,
  output logic              clear_o
);

  row_t                 row;
  logic [FILL_W-1:0]    fill;
  logic                 byp_hit;

  always_comb begin
    byp_hit = byp_i.en && (byp_i.bucket == bucket_i);
    row     = rd_row_i;
    fill    = rd_fill_i;
    // The row was read on the same edge the previous insert was written.
    if (byp_hit) begin
      row[byp_i.way] = byp_i.entry;
      fill           = byp_i.fill;
    end
    if (!bkt_vld_i) begin
      fill = '0;
    end

    res_o        = '0;
    wr_o         = '0;
    wr_o.bucket  = bucket_i;
    wr_o.way     = fill[WAY_W-1:0];
    wr_o.fill    = fill + FILL_W'(1);
    wr_o.entry   = '{ip: ip_i, mac: mac_i};
    clear_o      = 1'b0;

    case (cmd_e'(cmd_i))
      CMD_INSERT: begin
        if (fill < FILL_W'(WAYS_PER_BUCKET)) begin
          wr_o.en = 1'b1;
        end else begin
          res_o.full = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        // Scan from the newest way down so the oldest match wins.
        for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
          if ((FILL_W'(w) < fill) && (row[w].ip == ip_i)) begin
            res_o.found = 1'b1;
            res_o.mac   = row[w].mac;
          end
        end
      end
      CMD_CLEAR: begin
        clear_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/arp_hash_table.sv
// Result path: an accepted request waits in the stage-one registers, and its result
// is loaded into the result register once that register is free or drains.
// Throughput: one request per cycle while the result side is not stalled, insert,
// lookup and clear alike; the one bucket-row read per request and its write-back set this.
// Reset: asynchronous, active low. It empties the table at once by clearing
// the per-bucket valid bits; no clearing pass runs and no request is held.
// ----------------------------------------------------------------------------
// ARP hash table
// Hashed IPv4-to-MAC table with insert, lookup and clear requests.
// ----------------------------------------------------------------------------
module arp_hash_table import arpht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,   // [31:0] ip_addr, [79:32] mac_in
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [47:0] mac_out
  output logic [1:0]  m_axis_tuser_o    // [0] found, [1] bucket_full
);

  // Pipeline: the accept edge captures the request and reads its bucket row
  // and fill count from storage. Stage one then resolves the request
  // against that row, writes any insert back and registers the result when it retires.
  logic              in_fire;
  logic              s1_fire;
  logic              s1_vld_q;
  logic [1:0]        s1_cmd_q;
  logic [IP_W-1:0]   s1_ip_q;
  logic [MAC_W-1:0]  s1_mac_q;
  logic [BKT_W-1:0]  s1_bucket;
  logic [IP_W-1:0]   in_ip;

  // The write retired on the same edge as the current row read; the read
  // returned the old contents, so the write is merged back in.
  logic              byp_vld_q;
  wr_req_t           byp_q;
  wr_req_t           byp;

  logic              out_vld_q;
  result_t           out_q;

  row_t              rd_row;
  logic [FILL_W-1:0] rd_fill;
  logic              bkt_vld;
  result_t           res;
  wr_req_t           wr_req;
  wr_req_t           wr_gated;
  logic              clear_req;

  assign in_ip     = s_axis_tdata_i[IP_W-1:0];
  assign s1_bucket = bucket_of(s1_ip_q);

  // A request in stage one retires when the result register is free or drains.
  assign s1_fire         = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || s1_fire;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    byp    = byp_q;
    byp.en = byp_vld_q;
    wr_gated    = wr_req;
    wr_gated.en = wr_req.en && s1_fire;
  end

  arpht_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (in_fire),
    .rd_bucket_i  (bucket_of(in_ip)),
    .rd_row_o     (rd_row),
    .rd_fill_o    (rd_fill),
    .vld_bucket_i (s1_bucket),
    .vld_o        (bkt_vld),
    .wr_i         (wr_gated),
    .clear_i      (clear_req && s1_fire)
  );

  arpht_core u_core (
    .cmd_i     (s1_cmd_q),
    .ip_i      (s1_ip_q),
    .mac_i     (s1_mac_q),
    .bucket_i  (s1_bucket),
    .rd_row_i  (rd_row),
    .rd_fill_i (rd_fill),
    .bkt_vld_i (bkt_vld),
    .byp_i     (byp),
    .res_o     (res),
    .wr_o      (wr_req),
    .clear_o   (clear_req)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q  <= 1'b1;
        byp_vld_q <= wr_gated.en;
      end else if (s1_fire) begin
        s1_vld_q  <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q <= s_axis_tuser_i;
      s1_ip_q  <= in_ip;
      s1_mac_q <= s_axis_tdata_i[IP_W+MAC_W-1:IP_W];
      byp_q    <= wr_gated;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tdata_o    = out_q.mac;
  assign m_axis_tuser_o[0] = out_q.found;
  assign m_axis_tuser_o[1] = out_q.full;

endmodule

### hw/rtl/arpht_checker.sv
// ----------------------------------------------------------------------------
// ARP hash table checker
// Port-level assertions on the table's request and result channels.
// ----------------------------------------------------------------------------
module arpht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // A result is held while the downstream side stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result changed while stalled");

  // A request never both hits and reports a full bucket.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("found and bucket_full both set");

  // The MAC field is zero unless a lookup hit.
  a_mac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == 48'd0))
    else $error("mac_out nonzero without a hit");

  // With the result register empty, the input side is always open.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // No result appears straight out of reset.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid after reset");

endmodule

bind arp_hash_table arpht_checker u_arpht_checker (.*);

### dv/arp_hash_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP hash table testbench
// Drives insert, lookup, clear and unused requests into the table with random
// gaps and reply stalls. It predicts every reply from a shadow copy of the
// buckets and compares each returned reply with the oldest one still due.
// ----------------------------------------------------------------------------
module arp_hash_table_test;
  import arpht_pkg::*;

  // Command code that the table does not use. It must answer with all zeros.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Cycles without any handshake on either side before the run is abandoned.
  localparam int QUIET_LIMIT = 1000;

  // Shadow copy of the table plus the queue of replies still owed by the block.
  class arp_table_mirror;
    logic [IP_W-1:0]  way_ip  [NUM_BUCKETS][WAYS_PER_BUCKET];
    logic [MAC_W-1:0] way_mac [NUM_BUCKETS][WAYS_PER_BUCKET];
    int unsigned      way_fill[NUM_BUCKETS];
    result_t          replies_due[$];
    int errors;
    int n_insert, n_dropped, n_lookup, n_hit, n_clear, n_unused;

    function new();
      foreach (way_fill[b]) way_fill[b] = 0;
      errors = 0;
      n_insert = 0; n_dropped = 0; n_lookup = 0; n_hit = 0; n_clear = 0; n_unused = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Applies one accepted request to the shadow table and queues its reply.
    function void note_request(logic [1:0] cmd, logic [IP_W-1:0] ip,
                               logic [MAC_W-1:0] mac);
      result_t     reply;
      int unsigned b;
      reply = '0;
      b = int'(ip % NUM_BUCKETS);
      case (cmd)
        CMD_INSERT: begin
          n_insert++;
          if (way_fill[b] < WAYS_PER_BUCKET) begin
            way_ip[b][way_fill[b]]  = ip;
            way_mac[b][way_fill[b]] = mac;
            way_fill[b]++;
          end else begin
            reply.full = 1'b1;
            n_dropped++;
          end
        end
        CMD_LOOKUP: begin
          n_lookup++;
          // The oldest matching way wins, so duplicates return the first MAC.
          for (int w = 0; w < way_fill[b]; w++) begin
            if (way_ip[b][w] == ip) begin
              reply.found = 1'b1;
              reply.mac   = way_mac[b][w];
              n_hit++;
              break;
            end
          end
        end
        CMD_CLEAR: begin
          n_clear++;
          foreach (way_fill[i]) way_fill[i] = 0;
        end
        default: n_unused++;
      endcase
      replies_due.push_back(reply);
    endfunction

    function void check_reply(logic found, logic [MAC_W-1:0] mac, logic full);
      result_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none due: expected nothing, got found=%0b mac=%h full=%0b",
                 $time, found, mac, full);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (found !== want.found) begin
        $display("%0t: found mismatch: expected %0b, got %0b", $time, want.found, found);
        errors++;
      end
      if (mac !== want.mac) begin
        $display("%0t: mac_out mismatch: expected %h, got %h", $time, want.mac, mac);
        errors++;
      end
      if (full !== want.full) begin
        $display("%0t: bucket_full mismatch: expected %0b, got %0b", $time, want.full, full);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i = '0;   // [31:0] ip_addr, [79:32] mac_in
  logic [1:0]  s_axis_tuser_i = '0;   // [1:0] command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;        // [47:0] mac_out
  logic [1:0]  m_axis_tuser_o;        // [0] found, [1] bucket_full

  arp_table_mirror  mirror = new();
  logic             calm = 1'b0;     // when set, neither side idles
  int unsigned      hot_base = 0;    // first of the few buckets a phase hammers
  int               stall_left = 0;
  int               quiet_cycles = 0;
  logic [IP_W-1:0]  known_ips[$];

  arp_hash_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap(int longest);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, longest);
  endfunction

  // An address in one of the few buckets the current phase concentrates on,
  // with random upper bits so that distinct addresses share a bucket.
  function automatic logic [IP_W-1:0] hot_ip();
    logic [IP_W-1:0] raw;
    raw = $urandom();
    return raw - raw % NUM_BUCKETS + (hot_base + $urandom_range(0, 5)) % NUM_BUCKETS;
  endfunction

  // Receiver: stalls of random length, released entirely while calm is set.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      stall_left <= pick_gap(60);
    end
  end

  // Both handshakes are sampled with the values held just before the edge.
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o)
      mirror.note_request(s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[79:32]);
    if (m_axis_tvalid_o && m_axis_tready_i)
      mirror.check_reply(m_axis_tuser_o[0], m_axis_tdata_o, m_axis_tuser_o[1]);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no handshake for %0d cycles, %0d replies still due",
             $time, QUIET_LIMIT, mirror.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Presents one request, after an optional gap, and returns on the edge that
  // accepts it. tvalid stays high when the next request follows at once.
  task automatic send_req(logic [1:0] cmd, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    int gap;
    gap = pick_gap(40);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {mac, ip};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Holds the sender idle until the block has answered every request. The
  // first wait lets the monitor note the request accepted on the last edge.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic on a few crowded buckets: inserts (some of
  // them duplicates), lookups of stored addresses, occasional clears and unused
  // commands, and a little noise of any command with a fully random address.
  task automatic random_request();
    int               r;
    logic [1:0]       cmd;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    r   = $urandom_range(0, 99);
    mac = {16'($urandom()), 32'($urandom())};
    ip  = hot_ip();
    if (r < 42) begin
      cmd = CMD_INSERT;
      if (r < 8 && known_ips.size() > 0)
        ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
      known_ips.push_back(ip);
      if (known_ips.size() > 64) void'(known_ips.pop_front());
    end else if (r < 90) begin
      cmd = CMD_LOOKUP;
      if (r < 76 && known_ips.size() > 0)
        ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
    end else if (r < 93) begin
      cmd = CMD_CLEAR;
    end else if (r < 95) begin
      cmd = CMD_UNUSED;
    end else begin
      cmd = 2'($urandom_range(0, 3));
      ip  = $urandom();
    end
    send_req(cmd, ip, mac);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The addresses ending in 05, 0105, 0085 and ff85 all fall
    // in bucket 5 of a 128-bucket table; 0 and 0100 share bucket 0.
    send_req(CMD_LOOKUP, 32'h0000_0000, 48'h0);               // empty table
    send_req(CMD_INSERT, 32'h0000_0000, 48'h0000_0000_0000);
    send_req(CMD_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_req(CMD_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);  // mac_in ignored
    send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_req(CMD_INSERT, 32'h0A00_0005, 48'h1111_2222_3333);
    send_req(CMD_INSERT, 32'h0A00_0005, 48'h4444_5555_6666);  // duplicate address
    send_req(CMD_INSERT, 32'hC0A8_0105, 48'hA5A5_A5A5_A5A5);
    send_req(CMD_INSERT, 32'h7F00_0085, 48'h5A5A_5A5A_5A5A);  // bucket now full
    send_req(CMD_INSERT, 32'hFFFF_FF85, 48'hDEAD_BEEF_0001);  // dropped
    send_req(CMD_LOOKUP, 32'h0A00_0005, 48'h0);               // oldest duplicate
    send_req(CMD_LOOKUP, 32'hC0A8_0105, 48'h0);
    send_req(CMD_LOOKUP, 32'hFFFF_FF85, 48'h0);               // never stored
    send_req(CMD_LOOKUP, 32'h0000_0005, 48'h0);               // same bucket, no match
    send_req(CMD_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_req(CMD_LOOKUP, 32'h0000_0100, 48'h0);
    send_req(CMD_CLEAR,  32'h0A00_0005, 48'hFFFF_FFFF_FFFF);
    send_req(CMD_LOOKUP, 32'h0A00_0005, 48'h0);               // old words unreadable
    send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_req(CMD_INSERT, 32'h0A00_0005, 48'h0123_4567_89AB);
    send_req(CMD_LOOKUP, 32'h0A00_0005, 48'h0);
    drain();

    // Random part in phases, each on its own crowded buckets. The third
    // phase runs without idling on either side.
    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      hot_base = $urandom_range(0, NUM_BUCKETS - 1);
      repeat (158) random_request();
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk_i);
    if (mirror.pending() != 0) begin
      $display("%0t: replies outstanding: expected 0, got %0d", $time, mirror.pending());
      mirror.errors++;
    end
    $display("Covered %0d inserts (%0d dropped on a full bucket), %0d lookups (%0d hits),",
             mirror.n_insert, mirror.n_dropped, mirror.n_lookup, mirror.n_hit);
    $display("%0d clears and %0d unused commands, with random gaps and reply stalls.",
             mirror.n_clear, mirror.n_unused);
    if (mirror.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
